// ----- hdl/pim_pkg.sv -----
package pim_pkg;

    localparam int MAX_WAITERS   = 16;
    localparam int TASK_ID_BITS  = 6;
    localparam int PRIORITY_BITS = 8;
    localparam int IDX_BITS      = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_WAITERS + 1);

    localparam logic ACT_LOCK   = 1'b0;
    localparam logic ACT_UNLOCK = 1'b1;

    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_QUEUED    = 3'd1,
        STAT_FREED     = 3'd2,
        STAT_HANDOFF   = 3'd3,
        STAT_NOT_OWNER = 3'd4,
        STAT_FULL      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    typedef struct packed {
        logic [TASK_ID_BITS-1:0]  id;
        logic [PRIORITY_BITS-1:0] prio;
    } waiter_t;

    typedef struct packed {
        status_t                  status;
        logic [TASK_ID_BITS-1:0]  granted_task;
        logic                     boost_valid;
        logic [TASK_ID_BITS-1:0]  boost_task;
        logic [PRIORITY_BITS-1:0] boost_priority;
        logic                     restore_base;
    } result_t;

endpackage

// ----- hdl/priority_inheritance_mutex.sv -----
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------------------
// request  | req_valid | req_stall | action, task_id, task_priority
// response | rsp_valid | rsp_stall | status, granted_task, boost_valid, boost_task,
//          |           |           | boost_priority, restore_base
//
// Lock, and unlock without waiters or by a non-owner: result valid in the cycle after accept.
// Unlock with waiters: the waiter memory is scanned for the best waiter, then entries above the
// chosen one are shifted down before the handoff result is given.
// The waiter memory has one read port. No clearing pass after reset.
// req_stall is high while a handoff is in progress or a result is held by rsp_stall.
module priority_inheritance_mutex
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                action,
    input  logic [pim_pkg::TASK_ID_BITS-1:0]    task_id,
    input  logic [pim_pkg::PRIORITY_BITS-1:0]   task_priority,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [2:0]                          status,
    output logic [pim_pkg::TASK_ID_BITS-1:0]    granted_task,
    output logic                                boost_valid,
    output logic [pim_pkg::TASK_ID_BITS-1:0]    boost_task,
    output logic [pim_pkg::PRIORITY_BITS-1:0]   boost_priority,
    output logic                                restore_base
);

    pim_pkg::waiter_t mem [pim_pkg::MAX_WAITERS];

    pim_pkg::state_t                    state_reg, state_next;
    logic                               locked_reg, locked_next;
    logic [pim_pkg::TASK_ID_BITS-1:0]   owner_id_reg, owner_id_next;
    logic [pim_pkg::PRIORITY_BITS-1:0]  owner_prio_reg, owner_prio_next;
    logic [pim_pkg::CNT_BITS-1:0]       count_reg, count_next;
    logic [pim_pkg::CNT_BITS-1:0]       issue_reg, issue_next;
    logic                               pend_reg, pend_next;
    logic [pim_pkg::IDX_BITS-1:0]       pend_idx_reg, pend_idx_next;
    pim_pkg::waiter_t                   best_reg, best_next;
    logic [pim_pkg::IDX_BITS-1:0]       best_idx_reg, best_idx_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    pim_pkg::result_t                   res_reg, res_next;
    pim_pkg::waiter_t                   rd_data_reg;

    logic                               mem_we;
    logic [pim_pkg::IDX_BITS-1:0]       mem_waddr;
    pim_pkg::waiter_t                   mem_wdata;
    logic [pim_pkg::IDX_BITS-1:0]       rd_addr;
    logic                               accept;
    logic [pim_pkg::CNT_BITS-1:0]       last_idx;

    assign req_stall = (state_reg != pim_pkg::ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign last_idx  = count_reg - pim_pkg::CNT_BITS'(1);
    assign rd_addr   = issue_reg[pim_pkg::IDX_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        locked_next     = locked_reg;
        owner_id_next   = owner_id_reg;
        owner_prio_next = owner_prio_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        unique case (state_reg)
            pim_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (action == pim_pkg::ACT_LOCK)
                    begin
                        rsp_valid_next = 1'b1;
                        if (!locked_reg)
                        begin
                            locked_next           = 1'b1;
                            owner_id_next         = task_id;
                            owner_prio_next       = task_priority;
                            res_next.status       = pim_pkg::STAT_GRANTED;
                            res_next.granted_task = task_id;
                        end
                        else if (count_reg == pim_pkg::CNT_BITS'(pim_pkg::MAX_WAITERS))
                        begin
                            res_next.status = pim_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = count_reg[pim_pkg::IDX_BITS-1:0];
                            mem_wdata.id    = task_id;
                            mem_wdata.prio  = task_priority;
                            count_next      = count_reg + pim_pkg::CNT_BITS'(1);
                            res_next.status = pim_pkg::STAT_QUEUED;
                            if (task_priority < owner_prio_reg)
                            begin
                                owner_prio_next         = task_priority;
                                res_next.boost_valid    = 1'b1;
                                res_next.boost_task     = owner_id_reg;
                                res_next.boost_priority = task_priority;
                            end
                        end
                    end
                    else if (!locked_reg || task_id != owner_id_reg)
                    begin
                        rsp_valid_next  = 1'b1;
                        res_next.status = pim_pkg::STAT_NOT_OWNER;
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_valid_next        = 1'b1;
                        locked_next           = 1'b0;
                        owner_id_next         = '0;
                        owner_prio_next       = '0;
                        res_next.status       = pim_pkg::STAT_FREED;
                        res_next.restore_base = 1'b1;
                    end
                    else
                    begin
                        issue_next = '0;
                        pend_next  = 1'b0;
                        state_next = pim_pkg::ST_SCAN;
                    end
                end
            end

            pim_pkg::ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    issue_next    = issue_reg + pim_pkg::CNT_BITS'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (pend_idx_reg == '0 || rd_data_reg.prio < best_reg.prio)
                    begin
                        best_next     = rd_data_reg;
                        best_idx_next = pend_idx_reg;
                    end
                    if (pim_pkg::CNT_BITS'(pend_idx_reg) == last_idx)
                    begin
                        issue_next = pim_pkg::CNT_BITS'(best_idx_next) + pim_pkg::CNT_BITS'(1);
                        pend_next  = 1'b0;
                        state_next = pim_pkg::ST_SHIFT;
                    end
                end
            end

            pim_pkg::ST_SHIFT:
            begin
                if (issue_reg < count_reg)
                begin
                    issue_next    = issue_reg + pim_pkg::CNT_BITS'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg - pim_pkg::IDX_BITS'(1);
                    mem_wdata = rd_data_reg;
                end
                else if (issue_reg >= count_reg)
                begin
                    owner_id_next         = best_reg.id;
                    owner_prio_next       = best_reg.prio;
                    count_next            = last_idx;
                    rsp_valid_next        = 1'b1;
                    res_next              = '0;
                    res_next.status       = pim_pkg::STAT_HANDOFF;
                    res_next.granted_task = best_reg.id;
                    res_next.restore_base = 1'b1;
                    state_next            = pim_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pim_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pim_pkg::ST_IDLE;
            locked_reg     <= 1'b0;
            owner_id_reg   <= '0;
            owner_prio_reg <= '0;
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            locked_reg     <= locked_next;
            owner_id_reg   <= owner_id_next;
            owner_prio_reg <= owner_prio_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = res_reg.status;
    assign granted_task   = res_reg.granted_task;
    assign boost_valid    = res_reg.boost_valid;
    assign boost_task     = res_reg.boost_task;
    assign boost_priority = res_reg.boost_priority;
    assign restore_base   = res_reg.restore_base;

endmodule
